// ===== rtl/core/quadrature_decoder_bounded_count_assert.svh =====
// Assertion macros for the quadrature decoder checker.
// Every macro expects clk in scope; the first two also expect rst_n.
`ifndef QUADRATURE_DECODER_BOUNDED_COUNT_ASSERT_SVH
`define QUADRATURE_DECODER_BOUNDED_COUNT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define QDBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qdbc assertion failed");

// Next-cycle implication, off during reset.
`define QDBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qdbc assertion failed");

// Next-cycle implication that also holds through reset.
`define QDBC_ASSERT_NEXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qdbc assertion failed");

`endif

// ===== rtl/core/qdbc_pkg.sv =====
// ----------------------------------------------------------------------------
// qdbc_pkg
// Types, codes and the phase transition table of the quadrature decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qdbc_pkg;

  localparam int CountW = 16;

  typedef logic signed [CountW-1:0] count_t;
  typedef logic [2:0]               phase_t;
  typedef logic [1:0]               mode_t;
  typedef logic [1:0]               col_t;

  // item kinds
  localparam mode_t MODE_SAMPLE = 2'd0;
  localparam mode_t MODE_LOAD   = 2'd1;
  localparam mode_t MODE_START  = 2'd2;

  // config register indexes
  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  // edge columns
  localparam col_t COL_FALL_A = 2'd0;
  localparam col_t COL_RISE_A = 2'd1;
  localparam col_t COL_FALL_B = 2'd2;
  localparam col_t COL_RISE_B = 2'd3;

  localparam phase_t PHASE_DETENT = 3'd3;

  localparam count_t COUNT_MIN_RST = 16'sh8000;
  localparam count_t COUNT_MAX_RST = 16'sh7fff;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef struct packed {
    phase_t nxt;
    step_t  step;
  } phase_move_t;

  typedef struct packed {
    phase_t phase;
    logic   step_up;
    logic   step_down;
  } phase_res_t;

  function automatic phase_t pick4(col_t col, phase_t n0, phase_t n1,
                                   phase_t n2, phase_t n3);
    phase_t r;
    case (col)
      COL_FALL_A: r = n0;
      COL_RISE_A: r = n1;
      COL_FALL_B: r = n2;
      default:    r = n3;
    endcase
    return r;
  endfunction

  function automatic phase_move_t phase_move(phase_t st, col_t col);
    phase_move_t m;
    m.step = STEP_NONE;
    case (st)
      3'd0:    m.nxt = pick4(col, 3'd0, 3'd1, 3'd0, 3'd2);
      3'd1:    m.nxt = pick4(col, 3'd0, 3'd1, 3'd1, 3'd3);
      3'd2:    m.nxt = pick4(col, 3'd2, 3'd3, 3'd0, 3'd2);
      3'd3:    m.nxt = pick4(col, 3'd2, 3'd3, 3'd5, 3'd3);
      3'd4:    m.nxt = pick4(col, 3'd4, 3'd5, 3'd4, 3'd6);
      3'd5:    m.nxt = pick4(col, 3'd4, 3'd5, 3'd5, 3'd3);
      3'd6:    m.nxt = pick4(col, 3'd6, 3'd3, 3'd4, 3'd6);
      default: m.nxt = PHASE_DETENT; // illegal phase falls back to detent
    endcase
    if (st == 3'd1 && col == COL_RISE_B) begin
      m.step = STEP_UP;
    end else if (st == 3'd6 && col == COL_RISE_A) begin
      m.step = STEP_DOWN;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qdbc_phase.sv =====
// ----------------------------------------------------------------------------
// qdbc_phase
// Walks the phase machine through the A edge and then the B edge of a sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qdbc_phase (
  input  qdbc_pkg::phase_t     phase_in,
  input  logic                 last_a,
  input  logic                 last_b,
  input  logic                 a_level,
  input  logic                 b_level,
  output qdbc_pkg::phase_res_t res
);
  import qdbc_pkg::*;

  phase_move_t mv_a;
  phase_move_t mv_b;
  phase_t      ph_a;
  step_t       st_a;
  step_t       st_b;

  always_comb begin
    mv_a = phase_move(phase_in, a_level ? COL_RISE_A : COL_FALL_A);
    ph_a = (a_level != last_a) ? mv_a.nxt : phase_in;
    st_a = (a_level != last_a) ? mv_a.step : STEP_NONE;

    mv_b = phase_move(ph_a, b_level ? COL_RISE_B : COL_FALL_B);

    res.phase = (b_level != last_b) ? mv_b.nxt : ph_a;
    st_b      = (b_level != last_b) ? mv_b.step : STEP_NONE;

    res.step_up   = (st_a == STEP_UP)   || (st_b == STEP_UP);
    res.step_down = (st_a == STEP_DOWN) || (st_b == STEP_DOWN);
  end

endmodule

`default_nettype wire

// ===== rtl/core/qdbc_count.sv =====
// ----------------------------------------------------------------------------
// qdbc_count
// Next position: saturating step, clamped load or midpoint on start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qdbc_count (
  input  qdbc_pkg::mode_t  mode,
  input  qdbc_pkg::count_t pos,
  input  qdbc_pkg::count_t min_value,
  input  qdbc_pkg::count_t max_value,
  input  qdbc_pkg::count_t new_value,
  input  logic             step_up,
  input  logic             step_down,
  output qdbc_pkg::count_t pos_nxt
);
  import qdbc_pkg::*;

  logic signed [CountW:0] sum;
  logic signed [CountW:0] sum_adj;
  count_t                 mid;
  count_t                 loaded;

  always_comb begin
    sum     = {min_value[CountW-1], min_value} + {max_value[CountW-1], max_value};
    // round toward zero: bump negative sums before the shift
    sum_adj = sum + {{CountW{1'b0}}, sum[CountW]};
    mid     = count_t'(sum_adj[CountW:1]);

    if (new_value < min_value) begin
      loaded = min_value;
    end else if (new_value > max_value) begin
      loaded = max_value;
    end else begin
      loaded = new_value;
    end

    pos_nxt = pos;
    case (mode)
      MODE_SAMPLE: begin
        if (step_up && pos < max_value) begin
          pos_nxt = pos + 16'sd1;
        end else if (step_down && pos > min_value) begin
          pos_nxt = pos - 16'sd1;
        end
      end
      MODE_LOAD:  pos_nxt = loaded;
      MODE_START: pos_nxt = mid;
      default:    pos_nxt = pos;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/quadrature_decoder_bounded_count.sv =====
// Path: an accepted item shows its result after the input register and then
// the result register; the result side can stall it between the two.
// Throughput: 1 item per cycle while the result side does not stall; the phase
// table step and the saturating counter update sit between the two registers.
// Reset: synchronous; limits go to -32768/32767, phase to detent, pins to 1,
// position to 0, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_decoder_bounded_count (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  qdbc_pkg::mode_t  in_mode,
  input  logic             in_a_level,
  input  logic             in_b_level,
  input  qdbc_pkg::count_t in_new_value,
  output logic             out_valid,
  input  logic             out_stall,
  output qdbc_pkg::count_t out_count,
  output logic             out_stepped_up,
  output logic             out_stepped_down,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  qdbc_pkg::count_t cfg_data
);
  import qdbc_pkg::*;

  // decoder state
  count_t min_r;
  count_t max_r;
  phase_t phase_r;
  logic   last_a_r;
  logic   last_b_r;
  count_t pos_r;

  // input stage
  logic   in_valid_r;
  mode_t  mode_r;
  logic   a_r;
  logic   b_r;
  count_t new_value_r;

  // result stage
  logic   out_valid_r;
  count_t out_count_r;
  logic   out_up_r;
  logic   out_down_r;

  phase_res_t ph_res;
  count_t     pos_nxt;
  logic       adv;
  logic       in_take;
  logic       is_sample;

  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign is_sample = (mode_r == MODE_SAMPLE);
  assign cfg_ready = 1'b1;

  qdbc_phase u_phase (
    .phase_in (phase_r),
    .last_a   (last_a_r),
    .last_b   (last_b_r),
    .a_level  (a_r),
    .b_level  (b_r),
    .res      (ph_res)
  );

  qdbc_count u_count (
    .mode      (mode_r),
    .pos       (pos_r),
    .min_value (min_r),
    .max_value (max_r),
    .new_value (new_value_r),
    .step_up   (ph_res.step_up),
    .step_down (ph_res.step_down),
    .pos_nxt   (pos_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= COUNT_MIN_RST;
      max_r       <= COUNT_MAX_RST;
      phase_r     <= PHASE_DETENT;
      last_a_r    <= 1'b1;
      last_b_r    <= 1'b1;
      pos_r       <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MIN) begin
          min_r <= cfg_data;
        end else begin
          max_r <= cfg_data;
        end
      end

      if (!in_valid_r || adv) begin
        in_valid_r <= in_take;
      end

      if (adv) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        if (is_sample) begin
          phase_r  <= ph_res.phase;
          last_a_r <= a_r;
          last_b_r <= b_r;
        end else if (mode_r == MODE_START) begin
          phase_r  <= {1'b0, b_r, a_r};
          last_a_r <= a_r;
          last_b_r <= b_r;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r      <= in_mode;
      a_r         <= in_a_level;
      b_r         <= in_b_level;
      new_value_r <= in_new_value;
    end
    if (adv) begin
      out_count_r <= pos_nxt;
      out_up_r    <= is_sample && ph_res.step_up;
      out_down_r  <= is_sample && ph_res.step_down;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_count        = out_count_r;
  assign out_stepped_up   = out_up_r;
  assign out_stepped_down = out_down_r;

endmodule

`default_nettype wire

// ===== rtl/core/qdbc_checker.sv =====
// ----------------------------------------------------------------------------
// qdbc_checker
// Port-level checks of the quadrature decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quadrature_decoder_bounded_count_assert.svh"

module qdbc_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire qdbc_pkg::count_t out_count,
  input wire logic             out_stepped_up,
  input wire logic             out_stepped_down
);

  // a stalled result holds
  `QDBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_count))

  // one item never finishes a cycle in both directions
  `QDBC_ASSERT_IMPL(a_step_excl, out_valid, !(out_stepped_up && out_stepped_down))

  // the input side only backs up behind a stalled result
  `QDBC_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

  // reset empties the result stage and clears the input stall
  `QDBC_ASSERT_NEXT_ALL(a_rst_empty, !rst_n, !out_valid && !in_stall)

endmodule

bind quadrature_decoder_bounded_count qdbc_checker u_qdbc_checker (.*);

`default_nettype wire
